// ----- hw/rtl/afu_pkg.sv -----
package afu_pkg;

    // Operation codes carried in the func field
    localparam logic [3:0] FN_ADD = 4'd0;
    localparam logic [3:0] FN_ADC = 4'd1;
    localparam logic [3:0] FN_SUB = 4'd2;
    localparam logic [3:0] FN_SBB = 4'd3;
    localparam logic [3:0] FN_INR = 4'd4;
    localparam logic [3:0] FN_DCR = 4'd5;
    localparam logic [3:0] FN_INX = 4'd6;
    localparam logic [3:0] FN_DCX = 4'd7;
    localparam logic [3:0] FN_DAD = 4'd8;
    localparam logic [3:0] FN_DAA = 4'd9;
    localparam logic [3:0] FN_CMC = 4'd10;
    localparam logic [3:0] FN_STC = 4'd11;
    localparam logic [3:0] FN_LDA = 4'd12;

    // Decimal adjust constants
    localparam logic [3:0] BCD_MAX_DIGIT = 4'd9;
    localparam logic [3:0] BCD_LOW_FIX   = 4'd6;
    localparam logic [8:0] BCD_HIGH_FIX  = 9'h060;

    typedef struct packed {
        logic [3:0]  func;
        logic [7:0]  operand;
        logic        to_accumulator;
        logic [15:0] pair_value;
        logic [15:0] hl_value;
    } afu_req_t;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_word;
        logic        flag_zero;
        logic        flag_sign;
        logic        flag_parity;
        logic        flag_carry;
        logic        flag_aux;
    } afu_rsp_t;

    // Architectural state: accumulator and flags
    typedef struct packed {
        logic [7:0] acc;
        logic       zero;
        logic       sign;
        logic       parity;
        logic       carry;
        logic       aux;
    } afu_state_t;

    function automatic logic even_parity(input logic [7:0] b);
        even_parity = ~(^b);
    endfunction

endpackage

// ----- hw/rtl/afu_core.sv -----
module afu_core (
    input  afu_pkg::afu_req_t   req,
    input  afu_pkg::afu_state_t state,
    output afu_pkg::afu_rsp_t   rsp,
    output afu_pkg::afu_state_t state_next
);

    logic       is_sub;
    logic [7:0] addend;
    logic       cin;
    logic [8:0] sum9;
    logic [4:0] low5;
    logic [7:0] incdec;
    logic [16:0] word17;
    logic       low_fix;
    logic [4:0] daa_low5;
    logic [8:0] daa_v1;
    logic       high_fix;
    logic [8:0] daa_v2;
    logic [7:0] zsp_byte;
    logic       zsp_upd;

    always_comb
    begin
        is_sub   = (req.func == afu_pkg::FN_SUB) || (req.func == afu_pkg::FN_SBB);
        addend   = is_sub ? ~req.operand : req.operand;
        case (req.func)
            afu_pkg::FN_ADC: cin = state.carry;
            afu_pkg::FN_SUB: cin = 1'b1;
            afu_pkg::FN_SBB: cin = ~state.carry;
            default:         cin = 1'b0;
        endcase
        sum9     = {1'b0, state.acc} + {1'b0, addend} + {8'd0, cin};
        low5     = {1'b0, state.acc[3:0]} + {1'b0, addend[3:0]} + {4'd0, cin};

        incdec   = (req.func == afu_pkg::FN_INR) ? req.operand + 8'd1 : req.operand - 8'd1;

        case (req.func)
            afu_pkg::FN_INX: word17 = {1'b0, req.pair_value} + 17'd1;
            afu_pkg::FN_DCX: word17 = {1'b0, req.pair_value - 16'd1};
            default:         word17 = {1'b0, req.pair_value} + {1'b0, req.hl_value};
        endcase

        // Decimal adjust: low digit first, then high digit on the adjusted value
        low_fix  = (state.acc[3:0] > afu_pkg::BCD_MAX_DIGIT) || state.aux;
        daa_low5 = {1'b0, state.acc[3:0]} + {1'b0, afu_pkg::BCD_LOW_FIX};
        daa_v1   = {1'b0, state.acc} + (low_fix ? {5'd0, afu_pkg::BCD_LOW_FIX} : 9'd0);
        high_fix = (daa_v1[8:4] > {1'b0, afu_pkg::BCD_MAX_DIGIT}) || state.carry;
        daa_v2   = daa_v1 + (high_fix ? afu_pkg::BCD_HIGH_FIX : 9'd0);

        state_next = state;
        rsp.result_byte = state.acc;
        rsp.result_word = 16'd0;
        zsp_byte = 8'd0;
        zsp_upd  = 1'b0;

        case (req.func)
            afu_pkg::FN_ADD, afu_pkg::FN_ADC, afu_pkg::FN_SUB, afu_pkg::FN_SBB:
            begin
                state_next.aux   = low5[4];
                state_next.carry = sum9[8] ^ is_sub;
                state_next.acc   = sum9[7:0];
                rsp.result_byte  = sum9[7:0];
                zsp_byte = sum9[7:0];
                zsp_upd  = 1'b1;
            end
            afu_pkg::FN_INR, afu_pkg::FN_DCR:
            begin
                state_next.aux = (req.func == afu_pkg::FN_INR) ? (incdec[3:0] == 4'd0)
                                                               : (req.operand[3:0] != 4'd0);
                if (req.to_accumulator)
                begin
                    state_next.acc = incdec;
                end
                rsp.result_byte = incdec;
                zsp_byte = incdec;
                zsp_upd  = 1'b1;
            end
            afu_pkg::FN_INX, afu_pkg::FN_DCX:
            begin
                rsp.result_word = word17[15:0];
            end
            afu_pkg::FN_DAD:
            begin
                rsp.result_word  = word17[15:0];
                state_next.carry = word17[16];
            end
            afu_pkg::FN_DAA:
            begin
                state_next.aux   = low_fix & daa_low5[4];
                state_next.carry = state.carry | daa_v2[8];
                state_next.acc   = daa_v2[7:0];
                rsp.result_byte  = daa_v2[7:0];
                zsp_byte = daa_v2[7:0];
                zsp_upd  = 1'b1;
            end
            afu_pkg::FN_CMC:
            begin
                state_next.carry = ~state.carry;
            end
            afu_pkg::FN_STC:
            begin
                state_next.carry = 1'b1;
            end
            afu_pkg::FN_LDA:
            begin
                state_next.acc  = req.operand;
                rsp.result_byte = req.operand;
            end
            default:
            begin
                state_next = state;
            end
        endcase

        if (zsp_upd)
        begin
            state_next.zero   = (zsp_byte == 8'd0);
            state_next.sign   = zsp_byte[7];
            state_next.parity = afu_pkg::even_parity(zsp_byte);
        end

        rsp.flag_zero   = state_next.zero;
        rsp.flag_sign   = state_next.sign;
        rsp.flag_parity = state_next.parity;
        rsp.flag_carry  = state_next.carry;
        rsp.flag_aux    = state_next.aux;
    end

endmodule

// ----- hw/rtl/cpu8080_arith_flag_unit.sv -----
// 8080 arithmetic and flag unit. Holds the accumulator and the Z, S, P, CY and
// AC flags (all zero after reset) and executes one operation per request: add,
// adc, sub, sbb, inr, dcr, inx, dcx, dad, daa, cmc, stc and load accumulator.
// Each request yields exactly one response carrying the byte result (the
// accumulator for pair and carry operations), the 16-bit pair result (zero for
// byte operations) and the flags after the operation. Unused func codes
// thirteen to fifteen change nothing. A request is registered on acceptance
// into the input stage; when that stage advances, the datapath evaluates it
// against the current accumulator and flags, updating them and loading the
// response register in the same edge. Throughput is one request per cycle for
// as long as responses are taken; the limit is the single accumulator/flag
// update per cycle, since every operation reads the flags written by the one
// before it.
module cpu8080_arith_flag_unit (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              req_valid,
    output logic              req_ready,
    input  afu_pkg::afu_req_t req_data,

    output logic              rsp_valid,
    input  logic              rsp_ready,
    output afu_pkg::afu_rsp_t rsp_data
);

    // Input stage
    logic                in_valid_reg;
    afu_pkg::afu_req_t   in_data_reg;

    // Architectural state
    afu_pkg::afu_state_t state_reg;
    afu_pkg::afu_state_t state_next;

    // Response stage
    logic                out_valid_reg;
    afu_pkg::afu_rsp_t   out_data_reg;
    afu_pkg::afu_rsp_t   rsp_next;

    logic                advance;

    // The input stage moves on when the response register is empty or is
    // being drained this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;

    afu_core u_core (
        .req        (in_data_reg),
        .state      (state_reg),
        .rsp        (rsp_next),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_data_reg <= req_data;
        end
        if (advance)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

endmodule

// ----- hw/rtl/afu_checker.sv -----
module afu_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input afu_pkg::afu_rsp_t rsp_data
);

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // Z, S and P come from the same byte: zero means positive and even parity
    a_zsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.flag_zero |-> !rsp_data.flag_sign && rsp_data.flag_parity)
        else $error("zero flag inconsistent with sign or parity");

    // Empty response register never blocks requests
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with empty response register");

    // A new response follows an accepted request through the input and response registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without matching request");

endmodule

bind cpu8080_arith_flag_unit afu_checker u_afu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
